@@ hw/rtl/dfb_pkg.sv @@
// Package for the DShot frame burst generator: types, constants and frame builder.
`timescale 1ns / 1ps

package dfb_pkg;

  // Channel count and frame store size
  localparam int CHANNELS    = 4;
  localparam int STORE_DEPTH = 4;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int CODE_LANES  = 4;

  // Frame and code widths
  localparam int FRAME_W = 16;
  localparam int CODE_W  = 16;
  localparam int THR_W   = 12;
  localparam int CH_W    = 3;
  localparam int SLOT_W  = 5;

  // DShot constants
  localparam logic [THR_W-1:0]   MIN_THR    = 12'd48;
  localparam logic [THR_W-1:0]   MAX_THR    = 12'd2047;
  localparam logic [THR_W-1:0]   THR_LIMIT  = MAX_THR - MIN_THR;
  localparam logic [FRAME_W-1:0] INIT_FRAME = 16'h0606;
  localparam int                 SLOTS      = 18;
  localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(SLOTS - 1);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes (paddr[2])
  localparam logic REG_CODE_ONE  = 1'b0;
  localparam logic REG_CODE_ZERO = 1'b1;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_REJECT = 1'b1
  } status_t;

  typedef logic [STORE_DEPTH-1:0][FRAME_W-1:0] frame_arr_t;
  typedef logic [CODE_LANES-1:0][CODE_W-1:0]   code_arr_t;

  // One queued job: a set acknowledge or a tick with its frame snapshot
  typedef struct packed {
    logic       is_tick;
    status_t    status;
    frame_arr_t frames;
  } job_t;

  // Frame = {(throttle + 48) << 1, checksum}, telemetry bit 0
  function automatic logic [FRAME_W-1:0] build_frame(input logic [THR_W-1:0] thr);
    logic [THR_W-1:0] sum;
    logic [11:0]      v;
    logic [3:0]       csum;
    sum  = thr + MIN_THR;
    v    = {sum[10:0], 1'b0};
    csum = v[3:0] ^ v[7:4] ^ v[11:8];
    return {v, csum};
  endfunction

endpackage

@@ hw/rtl/dfb_front.sv @@
// Front end: accepts items, checks set requests, holds the frame store, queues jobs.
`timescale 1ns / 1ps

module dfb_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [dfb_pkg::CH_W-1:0]     channel,
  input  logic [dfb_pkg::THR_W-1:0]    throttle,
  input  logic                         q_full,
  output logic                         push,
  output dfb_pkg::job_t                push_job
);
  import dfb_pkg::*;

  frame_arr_t frame_store;
  logic       accept;
  logic       bad;
  logic       is_tick;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_tick  = (op_t'(op) == OP_TICK);

  // Range check of a set request
  assign bad = (channel >= CH_W'(CHANNELS)) || (throttle > THR_LIMIT);

  // Job to the queue; a tick carries the store as it stands before this item
  always_comb begin
    push              = accept;
    push_job.is_tick  = is_tick;
    push_job.status   = (!is_tick && bad) ? STATUS_REJECT : STATUS_OK;
    push_job.frames   = frame_store;
  end

  // Frame store update on an accepted good set
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        frame_store[k] <= INIT_FRAME;
      end
    end else if (accept && !is_tick && !bad) begin
      frame_store[channel[STORE_IDX_W-1:0]] <= build_frame(throttle);
    end
  end

endmodule

@@ hw/rtl/dfb_queue.sv @@
// Short job queue between the front end and the burst sequencer.
`timescale 1ns / 1ps

module dfb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dfb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output dfb_pkg::job_t head_job
);
  import dfb_pkg::*;

  job_t              slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head_job  = slots_q[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_q[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue pop while empty");

endmodule

@@ hw/rtl/dfb_back.sv @@
// Back end: turns queued jobs into result transfers through an output register.
`timescale 1ns / 1ps

module dfb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  dfb_pkg::job_t               head_job,
  output logic                        pop,
  input  logic [dfb_pkg::CODE_W-1:0]  code_one,
  input  logic [dfb_pkg::CODE_W-1:0]  code_zero,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic [dfb_pkg::SLOT_W-1:0]  slot,
  output dfb_pkg::code_arr_t          codes,
  output logic                        last
);
  import dfb_pkg::*;

  logic [SLOT_W-1:0] slot_cnt;
  logic [SLOT_W-1:0] slot_cnt_next;
  logic              load;
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  code_arr_t         res_codes;
  logic              res_last;
  logic              frame_bit;

  // Result for the head job at the current slot
  always_comb begin
    res_status = head_job.is_tick ? STATUS_OK : head_job.status;
    res_slot   = head_job.is_tick ? slot_cnt : '0;
    res_last   = !head_job.is_tick || (slot_cnt == LAST_SLOT);
    frame_bit  = 1'b0;
    for (int k = 0; k < CODE_LANES; k++) begin
      res_codes[k] = '0;
      if (k < CHANNELS && k < STORE_DEPTH) begin
        frame_bit = head_job.frames[k][~slot_cnt[3:0]];
        if (head_job.is_tick && !slot_cnt[4]) begin
          res_codes[k] = frame_bit ? code_one : code_zero;
        end
      end
    end
  end

  // Advance when the output register is free or being drained
  always_comb begin
    load          = q_valid && (!out_valid || out_ready);
    pop           = load && res_last;
    slot_cnt_next = slot_cnt;
    if (load) begin
      slot_cnt_next = res_last ? '0 : slot_cnt + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      slot_cnt <= slot_cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      status <= res_status;
      slot   <= res_slot;
      codes  <= res_codes;
      last   <= res_last;
    end
  end

  // Checks
  a_slot_range: assert property (@(posedge clk) disable iff (rst) slot_cnt <= LAST_SLOT)
    else $error("slot counter out of range");
  a_reject_single: assert property (@(posedge clk) disable iff (rst)
      out_valid && (status == STATUS_REJECT) |-> last && (slot == '0))
    else $error("rejected set must be a single result");
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
      out_valid && last && (slot != '0) |-> (slot == LAST_SLOT))
    else $error("burst ended at wrong slot");
  a_mid_burst_counter: assert property (@(posedge clk) disable iff (rst)
      (slot_cnt != '0) |-> q_valid && head_job.is_tick)
    else $error("slot counter running without a tick job");

endmodule

@@ hw/rtl/dshot_frame_burst_generator.sv @@
// Top level of the DShot frame burst generator: config registers, front, queue, back.
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    op, channel, throttle
// out      out_valid / out_ready  status, slot, code_ch0..code_ch3, last
// config   psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// A set request yields one result; a tick yields 18 results, one per unstalled cycle.
// An item is taken every cycle while the 4-entry job queue has room; the
// back end drains one result per cycle unless out_ready holds it back.
// An accepted item is registered in the job queue and then in the output register.
// Synchronous reset loads every frame with the throttle-zero frame.
// The queue and output register let input and output stall independently.

module dshot_frame_burst_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [dfb_pkg::CH_W-1:0]     channel,
  input  logic [dfb_pkg::THR_W-1:0]    throttle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic [dfb_pkg::SLOT_W-1:0]   slot,
  output logic [dfb_pkg::CODE_W-1:0]   code_ch0,
  output logic [dfb_pkg::CODE_W-1:0]   code_ch1,
  output logic [dfb_pkg::CODE_W-1:0]   code_ch2,
  output logic [dfb_pkg::CODE_W-1:0]   code_ch3,
  output logic                         last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import dfb_pkg::*;

  logic [CODE_W-1:0] code_one;
  logic [CODE_W-1:0] code_zero;
  logic              cfg_wr;
  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;
  job_t              push_job;
  job_t              head_job;
  code_arr_t         codes;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_one  <= '0;
      code_zero <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CODE_ONE:  code_one  <= pwdata[CODE_W-1:0];
        REG_CODE_ZERO: code_zero <= pwdata[CODE_W-1:0];
        default:       code_one  <= code_one;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CODE_ONE:  prdata = {16'd0, code_one};
      REG_CODE_ZERO: prdata = {16'd0, code_zero};
      default:       prdata = '0;
    endcase
  end

  dfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .channel  (channel),
    .throttle (throttle),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  dfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head_job  (head_job)
  );

  dfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head_job  (head_job),
    .pop       (pop),
    .code_one  (code_one),
    .code_zero (code_zero),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .slot      (slot),
    .codes     (codes),
    .last      (last)
  );

  assign code_ch0 = codes[0];
  assign code_ch1 = codes[1];
  assign code_ch2 = codes[2];
  assign code_ch3 = codes[3];

endmodule

@@ dv/tb_dshot_frame_burst_generator.sv @@
// Self-checking testbench for the DShot frame burst generator.
`timescale 1ns / 1ps

module tb_dshot_frame_burst_generator;
  import dfb_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 6;

  // One set request or frame tick
  typedef struct {
    op_t               op;
    logic [CH_W-1:0]   channel;
    logic [THR_W-1:0]  throttle;
  } dshot_req_t;

  // One result beat of the burst
  typedef struct {
    status_t                           status;
    logic [SLOT_W-1:0]                 slot;
    logic [CODE_LANES-1:0][CODE_W-1:0] codes;
    logic                              last;
  } burst_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              op       = 1'b0;
  logic [CH_W-1:0]   channel  = '0;
  logic [THR_W-1:0]  throttle = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              status;
  logic [SLOT_W-1:0] slot;
  logic [CODE_W-1:0] code_ch0, code_ch1, code_ch2, code_ch3;
  logic              last;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  dshot_frame_burst_generator uut (.*);

  // Predictor state
  logic [FRAME_W-1:0] frame_copy [STORE_DEPTH];
  logic [CODE_W-1:0]  bit_one_code;
  logic [CODE_W-1:0]  bit_zero_code;

  dshot_req_t  pending_reqs [$];
  burst_beat_t expected_beats [$];

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 27;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame word: {(step + 48) * 2, xor of its three nibbles}
  function automatic logic [FRAME_W-1:0] dshot_word(input logic [THR_W-1:0] step);
    int unsigned val;
    logic [3:0]  crc;
    val = ((int'(step) + 48) * 2) % 4096;
    crc = 4'(val) ^ 4'(val >> 4) ^ 4'(val >> 8);
    return {12'(val), crc};
  endfunction

  // Work out the result beats of one transferred item
  task automatic predict_burst(input logic op_i, input logic [CH_W-1:0] ch,
                               input logic [THR_W-1:0] thr);
    burst_beat_t b;
    bit          reject;
    if (op_i == OP_SET) begin
      reject = (ch >= CHANNELS) || (thr > THR_LIMIT);
      if (!reject)
        frame_copy[ch[1:0]] = dshot_word(thr);
      b.status = reject ? STATUS_REJECT : STATUS_OK;
      b.slot   = '0;
      b.codes  = '0;
      b.last   = 1'b1;
      expected_beats.push_back(b);
    end else begin
      for (int s = 0; s < SLOTS; s++) begin
        b.status = STATUS_OK;
        b.slot   = SLOT_W'(s);
        b.codes  = '0;
        for (int k = 0; k < CODE_LANES; k++)
          if (k < CHANNELS && s < 16)
            b.codes[k] = frame_copy[k][15-s] ? bit_one_code : bit_zero_code;
        b.last = (s == SLOTS - 1);
        expected_beats.push_back(b);
      end
    end
  endtask

  task automatic note_error(input string what, input int unsigned exp_v,
                            input int unsigned act_v);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, exp_v, act_v);
  endtask

  // Driver: holds each item until its transfer, then pulls the next one
  always @(posedge clk) begin
    dshot_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predict_burst(op, channel, throttle);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          op       <= nxt.op;
          channel  <= nxt.channel;
          throttle <= nxt.throttle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and field-by-field compare
  always @(posedge clk) begin
    burst_beat_t b;
    logic [CODE_W-1:0] act_codes [CODE_LANES];
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          note_error("unexpected result", 0, slot);
        end else begin
          b = expected_beats.pop_front();
          act_codes[0] = code_ch0;
          act_codes[1] = code_ch1;
          act_codes[2] = code_ch2;
          act_codes[3] = code_ch3;
          if (status !== b.status) note_error("status", b.status, status);
          if (slot !== b.slot)     note_error("slot", b.slot, slot);
          for (int k = 0; k < CODE_LANES; k++)
            if (act_codes[k] !== b.codes[k])
              note_error($sformatf("code_ch%0d slot %0d", k, b.slot), b.codes[k], act_codes[k]);
          if (last !== b.last)     note_error("last", b.last, last);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // APB write with setup and access phases; the predictor follows it
  task automatic write_reg(input logic idx, input logic [CODE_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CODE_ONE) bit_one_code = val;
    else                     bit_zero_code = val;
  endtask

  // Block until every item is sent and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic dshot_req_t make_req(input op_t o, input int unsigned ch,
                                          input int unsigned thr);
    dshot_req_t r;
    r.op       = o;
    r.channel  = CH_W'(ch);
    r.throttle = THR_W'(thr);
    return r;
  endfunction

  // Mostly well-formed sets, some ticks, some out-of-range requests
  function automatic dshot_req_t random_req();
    int unsigned pick;
    int unsigned ch;
    int unsigned thr;
    pick = $urandom_range(99);
    ch   = ($urandom_range(99) < 85) ? $urandom_range(CHANNELS - 1) : $urandom_range(7, 4);
    if (pick < 80)      thr = $urandom_range(1999);
    else if (pick < 92) thr = $urandom_range(4095, 2000);
    else                thr = ($urandom_range(1)) ? (($urandom_range(1)) ? 0 : 1999)
                                                   : (($urandom_range(1)) ? 2000 : 4095);
    return make_req(($urandom_range(99) < 14) ? OP_TICK : OP_SET, ch, thr);
  endfunction

  initial begin
    logic [CODE_W-1:0] one_vals  [5];
    logic [CODE_W-1:0] zero_vals [5];

    for (int k = 0; k < STORE_DEPTH; k++)
      frame_copy[k] = INIT_FRAME;
    bit_one_code  = '0;
    bit_zero_code = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Tick straight out of reset: reset frames, zero codes
    pending_reqs.push_back(make_req(OP_TICK, 0, 0));
    wait_drained();

    write_reg(REG_CODE_ONE, 16'hFFFF);
    write_reg(REG_CODE_ZERO, 16'h0000);

    // Directed: reset frames visible, range edges, every reject path
    pending_reqs.push_back(make_req(OP_TICK, 7, 4095));
    pending_reqs.push_back(make_req(OP_SET, 0, 0));
    pending_reqs.push_back(make_req(OP_SET, 1, 1999));
    pending_reqs.push_back(make_req(OP_SET, 2, 2000));
    pending_reqs.push_back(make_req(OP_SET, 3, 4095));
    pending_reqs.push_back(make_req(OP_SET, 4, 100));
    pending_reqs.push_back(make_req(OP_SET, 7, 1999));
    pending_reqs.push_back(make_req(OP_SET, 3, 12'h555));
    pending_reqs.push_back(make_req(OP_SET, 2, 12'h2AA));
    pending_reqs.push_back(make_req(OP_TICK, 0, 0));
    pending_reqs.push_back(make_req(OP_SET, 0, 1000));
    pending_reqs.push_back(make_req(OP_SET, 1, 1));
    pending_reqs.push_back(make_req(OP_SET, 3, 1998));
    pending_reqs.push_back(make_req(OP_SET, 5, 0));
    pending_reqs.push_back(make_req(OP_SET, 6, 4095));
    pending_reqs.push_back(make_req(OP_TICK, 3, 2047));
    pending_reqs.push_back(make_req(OP_TICK, 4, 0));
    wait_drained();

    // Random phases, new code pair each time
    one_vals  = '{16'h0000, 16'($urandom), 16'($urandom), 16'hFFFF, 16'($urandom)};
    zero_vals = '{16'hFFFF, 16'($urandom), 16'($urandom), 16'hFFFF, 16'($urandom)};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_CODE_ONE, one_vals[p]);
      write_reg(REG_CODE_ZERO, zero_vals[p]);
      // one phase runs with no gaps on either side
      send_idle_pct = (p == 2) ? 0 : 27;
      recv_idle_pct = (p == 2) ? 0 : 27;
      for (int i = 0; i < 66; i++)
        pending_reqs.push_back(random_req());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
